// ===== src/irsf_pkg.sv =====
// Shared constants and the distance curve table for the IR range sensor filter chain.
`default_nettype none

package irsf_pkg;

    localparam int unsigned CODE_W          = 12;
    localparam int unsigned DIST_W          = 13;
    localparam int unsigned FRAC_W          = 7;
    localparam int unsigned CURVE_IDX_W     = 6;
    localparam int unsigned BLOCK_DEPTH_DEF = 16;
    localparam int unsigned WINDOW_DEPTH_DEF = 8;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CODE_W-1:0] NEAR_LIMIT_CODE = 12'd621;
    localparam logic [DIST_W-1:0] FAR_DISTANCE    = 13'd8000;

    // Distance curve in 0.01 cm, sampled at every code that is a multiple of 128.
    function automatic logic [DIST_W-1:0] curve_point(input logic [CURVE_IDX_W-1:0] idx);
        logic [DIST_W-1:0] pt;
        case (idx)
            6'd0:    pt = 13'd8000;
            6'd1:    pt = 13'd8000;
            6'd2:    pt = 13'd8000;
            6'd3:    pt = 13'd8000;
            6'd4:    pt = 13'd8054;
            6'd5:    pt = 13'd6155;
            6'd6:    pt = 13'd4942;
            6'd7:    pt = 13'd4104;
            6'd8:    pt = 13'd3495;
            6'd9:    pt = 13'd3032;
            6'd10:   pt = 13'd2671;
            6'd11:   pt = 13'd2381;
            6'd12:   pt = 13'd2144;
            6'd13:   pt = 13'd1947;
            6'd14:   pt = 13'd1781;
            6'd15:   pt = 13'd1639;
            6'd16:   pt = 13'd1516;
            6'd17:   pt = 13'd1410;
            6'd18:   pt = 13'd1316;
            6'd19:   pt = 13'd1233;
            6'd20:   pt = 13'd1159;
            6'd21:   pt = 13'd1093;
            6'd22:   pt = 13'd1033;
            6'd23:   pt = 13'd979;
            6'd24:   pt = 13'd930;
            6'd25:   pt = 13'd886;
            6'd26:   pt = 13'd845;
            6'd27:   pt = 13'd807;
            6'd28:   pt = 13'd773;
            6'd29:   pt = 13'd741;
            6'd30:   pt = 13'd711;
            6'd31:   pt = 13'd684;
            6'd32:   pt = 13'd658;
            default: pt = 13'd0;
        endcase
        return pt;
    endfunction

endpackage

`default_nettype wire

// ===== src/ir_range_sensor_filter_chain_unit.sv =====
// IR range sensor filter chain: sample store, moving-average ring and distance conversion.
// A read tick's result passes through the pipeline stages and the output register before it is valid.
// Throughput: one item (store or tick) per cycle while not held; each memory is read and
// written once a cycle. The whole pipeline holds while a result waits at the output register.
// Reset clears pointers, running totals and fill flags; memory entries not yet written
// since reset read as zero through the fill flags, so no clearing pass is needed.
`default_nettype none

module ir_range_sensor_filter_chain_unit #(
    parameter int unsigned BLOCK_DEPTH  = irsf_pkg::BLOCK_DEPTH_DEF,
    parameter int unsigned WINDOW_DEPTH = irsf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic                          cmd,
    input  logic [irsf_pkg::CODE_W-1:0]   adc_sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [irsf_pkg::CODE_W-1:0]   filtered_value,
    output logic [irsf_pkg::DIST_W-1:0]   distance_centi
);
    import irsf_pkg::*;

    localparam int unsigned BLK_L  = $clog2(BLOCK_DEPTH);
    localparam int unsigned WIN_L  = $clog2(WINDOW_DEPTH);
    localparam int unsigned SPTR_W = (BLOCK_DEPTH > 1) ? BLK_L : 1;
    localparam int unsigned APTR_W = (WINDOW_DEPTH > 1) ? WIN_L : 1;
    localparam int unsigned SUM_W  = CODE_W + BLK_L;
    localparam int unsigned AVG_W  = CODE_W + WIN_L;
    localparam int unsigned SH1    = SUM_W + BLK_L;
    localparam int unsigned SH2    = AVG_W + WIN_L;
    localparam int unsigned P1_W   = 2 * SUM_W + 1;
    localparam int unsigned P2_W   = 2 * AVG_W + 1;
    localparam int unsigned DPROD_W = DIST_W + FRAC_W;

    // Reciprocals for exact truncating division by the depths.
    localparam logic [63:0] M1_FULL =
        ((64'd1 << SH1) + 64'(BLOCK_DEPTH) - 64'd1) / 64'(BLOCK_DEPTH);
    localparam logic [63:0] M2_FULL =
        ((64'd1 << SH2) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [SUM_W:0] M1 = M1_FULL[SUM_W:0];
    localparam logic [AVG_W:0] M2 = M2_FULL[AVG_W:0];

    localparam logic [SPTR_W-1:0] SPTR_LAST = SPTR_W'(BLOCK_DEPTH - 1);
    localparam logic [APTR_W-1:0] APTR_LAST = APTR_W'(WINDOW_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(BLOCK_DEPTH * 4095);
    localparam logic [AVG_W-1:0]  AVG_MAX   = AVG_W'(WINDOW_DEPTH * 4095);

    logic advance;
    logic accept;

    // Pointers and fill flags.
    logic [SPTR_W-1:0] sptr_reg;
    logic [APTR_W-1:0] aptr_reg;
    logic              sample_full_reg;
    logic              ring_full_reg;

    // Stage 1.
    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [CODE_W-1:0] s1_sample_reg;
    logic [SPTR_W-1:0] s1_sptr_reg;
    logic [APTR_W-1:0] s1_aptr_reg;
    logic              s1_sfwd_reg;
    logic              s1_sold_ok_reg;
    logic              s1_aold_ok_reg;

    // Stage 2.
    logic              s2_valid_reg;
    logic [APTR_W-1:0] s2_aptr_reg;
    logic              s2_afwd_reg;
    logic              s2_aold_ok_reg;
    logic [P1_W-1:0]   prod1_reg;

    logic              s3_valid_reg;
    logic              s4_valid_reg;
    logic [P2_W-1:0]   prod2_reg;

    logic               s5_valid_reg;
    logic [CODE_W-1:0]  s5_filtered_reg;
    logic               s5_near_reg;
    logic [DIST_W-1:0]  s5_hi_reg;
    logic [DPROD_W-1:0] s5_prod_reg;

    logic              result_valid_reg;
    logic [CODE_W-1:0] filtered_value_reg;
    logic [DIST_W-1:0] distance_reg;

    // Running totals and memories.
    logic [SUM_W-1:0]  sample_total_reg;
    logic [SUM_W-1:0]  sample_total_next;
    logic [AVG_W-1:0]  average_total_reg;
    logic [AVG_W-1:0]  average_total_next;
    logic [CODE_W-1:0] sample_mem [BLOCK_DEPTH];
    logic [CODE_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [CODE_W-1:0] sample_rdata_reg;
    logic [CODE_W-1:0] ring_rdata_reg;
    logic [CODE_W-1:0] s_last_reg;
    logic [CODE_W-1:0] a_last_reg;

    logic              s1_store;
    logic              s1_tick;
    logic [CODE_W-1:0] sample_old;
    logic [CODE_W-1:0] block_avg;
    logic [CODE_W-1:0] ring_old;
    logic [CODE_W-1:0] filtered;
    logic [CURVE_IDX_W-1:0] curve_idx;
    logic [DIST_W-1:0] curve_hi;
    logic [DIST_W-1:0] curve_lo;
    logic [DIST_W-1:0] curve_diff;
    logic [DPROD_W:0]  drop_sum;
    logic [DIST_W-1:0] distance_next;

    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = advance;
    assign accept       = sample_valid && advance;

    assign s1_store = s1_valid_reg && (s1_cmd_reg == CMD_STORE);
    assign s1_tick  = s1_valid_reg && (s1_cmd_reg == CMD_TICK);

    // An entry not yet written since reset counts as zero; the entry the item just
    // ahead is writing this cycle comes from the forwarding register.
    always_comb
    begin
        if (s1_sfwd_reg)
        begin
            sample_old = s_last_reg;
        end
        else if (s1_sold_ok_reg)
        begin
            sample_old = sample_rdata_reg;
        end
        else
        begin
            sample_old = '0;
        end
        sample_total_next = sample_total_reg - SUM_W'(sample_old) + SUM_W'(s1_sample_reg);
    end

    assign block_avg = prod1_reg[SH1 +: CODE_W];

    always_comb
    begin
        if (s2_afwd_reg)
        begin
            ring_old = a_last_reg;
        end
        else if (s2_aold_ok_reg)
        begin
            ring_old = ring_rdata_reg;
        end
        else
        begin
            ring_old = '0;
        end
        average_total_next = average_total_reg - AVG_W'(ring_old) + AVG_W'(block_avg);
    end

    assign filtered   = prod2_reg[SH2 +: CODE_W];
    assign curve_idx  = {1'b0, filtered[CODE_W-1:FRAC_W]};
    assign curve_hi   = curve_point(curve_idx);
    assign curve_lo   = curve_point(curve_idx + CURVE_IDX_W'(1));
    assign curve_diff = curve_hi - curve_lo;

    always_comb
    begin
        drop_sum = {1'b0, s5_prod_reg} + (DPROD_W + 1)'(64);
        if (s5_near_reg)
        begin
            distance_next = FAR_DISTANCE;
        end
        else
        begin
            distance_next = s5_hi_reg - drop_sum[FRAC_W +: DIST_W];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sptr_reg          <= '0;
            aptr_reg          <= '0;
            sample_full_reg   <= 1'b0;
            ring_full_reg     <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            s4_valid_reg      <= 1'b0;
            s5_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            sample_total_reg  <= '0;
            average_total_reg <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg     <= sample_valid;
            s2_valid_reg     <= s1_tick;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            result_valid_reg <= s5_valid_reg;
            if (accept && (cmd == CMD_STORE))
            begin
                if (sptr_reg == SPTR_LAST)
                begin
                    sptr_reg        <= '0;
                    sample_full_reg <= 1'b1;
                end
                else
                begin
                    sptr_reg <= sptr_reg + SPTR_W'(1);
                end
            end
            if (accept && (cmd == CMD_TICK))
            begin
                if (aptr_reg == APTR_LAST)
                begin
                    aptr_reg      <= '0;
                    ring_full_reg <= 1'b1;
                end
                else
                begin
                    aptr_reg <= aptr_reg + APTR_W'(1);
                end
            end
            if (s1_store)
            begin
                sample_total_reg <= sample_total_next;
            end
            if (s2_valid_reg)
            begin
                average_total_reg <= average_total_next;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cmd_reg     <= cmd;
            s1_sample_reg  <= adc_sample;
            s1_sptr_reg    <= sptr_reg;
            s1_aptr_reg    <= aptr_reg;
            s1_sfwd_reg    <= s1_store && (s1_sptr_reg == sptr_reg);
            s1_sold_ok_reg <= sample_full_reg;
            s1_aold_ok_reg <= ring_full_reg;

            s2_aptr_reg    <= s1_aptr_reg;
            s2_afwd_reg    <= s2_valid_reg && (s2_aptr_reg == s1_aptr_reg);
            s2_aold_ok_reg <= s1_aold_ok_reg;
            prod1_reg      <= P1_W'(sample_total_reg * M1);

            prod2_reg      <= P2_W'(average_total_reg * M2);

            s5_filtered_reg <= filtered;
            s5_near_reg     <= (filtered < NEAR_LIMIT_CODE);
            s5_hi_reg       <= curve_hi;
            s5_prod_reg     <= DPROD_W'(curve_diff * filtered[FRAC_W-1:0]);

            filtered_value_reg <= s5_filtered_reg;
            distance_reg       <= distance_next;

            if (s1_store)
            begin
                s_last_reg <= s1_sample_reg;
            end
            if (s2_valid_reg)
            begin
                a_last_reg <= block_avg;
            end
        end
    end

    // Sample store: read at the pointer on entry, written back one stage later.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_rdata_reg <= sample_mem[sptr_reg];
            if (s1_store)
            begin
                sample_mem[s1_sptr_reg] <= s1_sample_reg;
            end
        end
    end

    // Average ring: read in stage 1, written back in stage 2.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ring_rdata_reg <= ring_mem[s1_aptr_reg];
            if (s2_valid_reg)
            begin
                ring_mem[s2_aptr_reg] <= block_avg;
            end
        end
    end

    assign result_valid   = result_valid_reg;
    assign filtered_value = filtered_value_reg;
    assign distance_centi = distance_reg;

    a_near_is_far: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (filtered_value_reg < NEAR_LIMIT_CODE))
            |-> (distance_reg == FAR_DISTANCE))
        else $error("near code did not give the far distance");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (distance_reg <= FAR_DISTANCE))
        else $error("distance above the far limit");

    a_sample_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sample_total_reg <= SUM_MAX)
        else $error("sample total exceeds the store capacity");

    a_average_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        average_total_reg <= AVG_MAX)
        else $error("ring total exceeds the ring capacity");

endmodule

`default_nettype wire

// ===== verif/ir_range_sensor_filter_chain_unit_tb.sv =====
// Self-checking testbench for the IR range sensor filter chain: directed table, then random items.
`default_nettype none

module ir_range_sensor_filter_chain_unit_tb;
    import irsf_pkg::*;

    localparam int BLOCK_DEPTH  = 16;
    localparam int WINDOW_DEPTH = 8;
    localparam int TARGET_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ROW_COUNT    = 25;

    typedef struct packed {
        logic [CODE_W-1:0] filtered;
        logic [DIST_W-1:0] distance;
    } reading_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] sample;
        logic              typed;
        logic [CODE_W-1:0] want_filtered;
        logic [DIST_W-1:0] want_distance;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_ready;
    logic              cmd;
    logic [CODE_W-1:0] adc_sample;
    logic              result_valid;
    logic              result_ready;
    logic [CODE_W-1:0] filtered_value;
    logic [DIST_W-1:0] distance_centi;

    // Predictor state.
    logic [CODE_W-1:0] model_samples [BLOCK_DEPTH];
    logic [3:0]        model_sample_ptr;
    logic [15:0]       model_sample_sum;
    logic [CODE_W-1:0] model_ring [WINDOW_DEPTH];
    logic [2:0]        model_ring_ptr;
    logic [14:0]       model_ring_sum;
    logic [DIST_W-1:0] curve_pts [0:32];

    reading_t   expected_readings [$];
    table_row_t directed_rows [0:ROW_COUNT-1];
    int         error_count;
    int         items_sent;
    int         burst_left;
    int         cycle_count;
    bit         hold_request;

    ir_range_sensor_filter_chain_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .cmd            (cmd),
        .adc_sample     (adc_sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .filtered_value (filtered_value),
        .distance_centi (distance_centi)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [DIST_W-1:0] distance_of(input logic [CODE_W-1:0] code);
        int seg;
        int frac;
        int hi;
        int lo;
        if (code < NEAR_LIMIT_CODE)
            return FAR_DISTANCE;
        seg  = int'(code) >> 7;
        frac = int'(code) & 127;
        hi   = int'(curve_pts[seg]);
        lo   = int'(curve_pts[seg + 1]);
        return DIST_W'(hi - ((hi - lo) * frac + 64) / 128);
    endfunction

    // Applies one item to the predictor; a read tick yields the filtered reading.
    task automatic advance_filter(input logic c, input logic [CODE_W-1:0] s,
                                  output bit produced, output reading_t r);
        logic [CODE_W-1:0] block_avg;
        produced = 1'b0;
        r        = '0;
        if (c == CMD_STORE)
        begin
            model_sample_sum = model_sample_sum - model_samples[model_sample_ptr] + s;
            model_samples[model_sample_ptr] = s;
            model_sample_ptr = model_sample_ptr + 1'b1;
        end
        else
        begin
            block_avg = CODE_W'(model_sample_sum / BLOCK_DEPTH);
            model_ring_sum = model_ring_sum - model_ring[model_ring_ptr] + block_avg;
            model_ring[model_ring_ptr] = block_avg;
            model_ring_ptr = model_ring_ptr + 1'b1;
            r.filtered = CODE_W'(model_ring_sum / WINDOW_DEPTH);
            r.distance = distance_of(r.filtered);
            produced   = 1'b1;
        end
    endtask

    // Offers one item, with random gaps between bursts, and predicts it once accepted.
    task automatic offer(input logic c, input logic [CODE_W-1:0] s,
                         input bit typed, input reading_t typed_reading);
        bit       produced;
        reading_t r;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                sample_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
        end
        burst_left--;
        @(negedge clk);
        sample_valid <= 1'b1;
        cmd          <= c;
        adc_sample   <= s;
        do @(posedge clk); while (!sample_ready);
        advance_filter(c, s, produced, r);
        if (produced)
            expected_readings.push_back(typed ? typed_reading : r);
        items_sent++;
    endtask

    task automatic go_quiet();
        @(negedge clk);
        sample_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Result consumer: stall pattern of its own, plus one long hold-off on request.
    initial
    begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    2:       result_ready <= ($urandom_range(0, 4) != 0);
                    default: result_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        reading_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("result with nothing expected: filtered %0d distance %0d",
                             filtered_value, distance_centi);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (filtered_value !== want.filtered || distance_centi !== want.distance)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: filtered exp %0d got %0d, distance exp %0d got %0d",
                                 want.filtered, filtered_value, want.distance, distance_centi);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ir_range_sensor_filter_chain_unit_tb: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        reading_t typed_r;
        reading_t no_reading;
        int       target;
        int       jitter;
        int       level;
        bit       pressure_done;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        cmd          = CMD_STORE;
        adc_sample   = '0;
        result_ready = 1'b0;
        hold_request = 1'b0;
        burst_left   = 0;
        items_sent   = 0;
        error_count  = 0;
        cycle_count  = 0;
        no_reading   = '0;
        pressure_done = 1'b0;

        curve_pts = '{13'd8000, 13'd8000, 13'd8000, 13'd8000, 13'd8054, 13'd6155, 13'd4942,
                      13'd4104, 13'd3495, 13'd3032, 13'd2671, 13'd2381, 13'd2144, 13'd1947,
                      13'd1781, 13'd1639, 13'd1516, 13'd1410, 13'd1316, 13'd1233, 13'd1159,
                      13'd1093, 13'd1033, 13'd979,  13'd930,  13'd886,  13'd845,  13'd807,
                      13'd773,  13'd741,  13'd711,  13'd684,  13'd658};

        foreach (model_samples[i])
            model_samples[i] = '0;
        foreach (model_ring[i])
            model_ring[i] = '0;
        model_sample_ptr = '0;
        model_sample_sum = '0;
        model_ring_ptr   = '0;
        model_ring_sum   = '0;

        // A tick right after reset sees an empty store and ring; then the store is filled
        // with extremes and the ring is walked past its wrap.
        directed_rows[0]  = '{CMD_TICK,  12'h000, 1'b1, 12'd0, FAR_DISTANCE};
        directed_rows[1]  = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[2]  = '{CMD_STORE, 12'h000, 1'b0, 12'd0, 13'd0};
        directed_rows[3]  = '{CMD_STORE, 12'hAAA, 1'b0, 12'd0, 13'd0};
        directed_rows[4]  = '{CMD_STORE, 12'h555, 1'b0, 12'd0, 13'd0};
        directed_rows[5]  = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[6]  = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[7]  = '{CMD_STORE, 12'h800, 1'b0, 12'd0, 13'd0};
        directed_rows[8]  = '{CMD_STORE, 12'h7FF, 1'b0, 12'd0, 13'd0};
        directed_rows[9]  = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[10] = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[11] = '{CMD_STORE, 12'h001, 1'b0, 12'd0, 13'd0};
        directed_rows[12] = '{CMD_STORE, 12'hFFE, 1'b0, 12'd0, 13'd0};
        directed_rows[13] = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[14] = '{CMD_STORE, 12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[15] = '{CMD_STORE, 12'h26D, 1'b0, 12'd0, 13'd0};
        directed_rows[16] = '{CMD_STORE, 12'h26C, 1'b0, 12'd0, 13'd0};
        directed_rows[17] = '{CMD_TICK,  12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[18] = '{CMD_TICK,  12'h000, 1'b0, 12'd0, 13'd0};
        directed_rows[19] = '{CMD_TICK,  12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[20] = '{CMD_TICK,  12'h000, 1'b0, 12'd0, 13'd0};
        directed_rows[21] = '{CMD_TICK,  12'hAAA, 1'b0, 12'd0, 13'd0};
        directed_rows[22] = '{CMD_TICK,  12'h555, 1'b0, 12'd0, 13'd0};
        directed_rows[23] = '{CMD_TICK,  12'hFFF, 1'b0, 12'd0, 13'd0};
        directed_rows[24] = '{CMD_TICK,  12'h000, 1'b0, 12'd0, 13'd0};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            typed_r.filtered = directed_rows[i].want_filtered;
            typed_r.distance = directed_rows[i].want_distance;
            offer(directed_rows[i].cmd, directed_rows[i].sample, directed_rows[i].typed, typed_r);
        end

        // Let the output side drain completely before the random part.
        go_quiet();
        wait (expected_readings.size() == 0);

        while (items_sent < TARGET_ITEMS)
        begin
            if (!pressure_done && items_sent > 700)
            begin
                // Receiver holds off while ticks keep coming, so the pipeline backs up.
                hold_request = 1'b1;
                repeat (40)
                    offer(($urandom_range(0, 3) == 0) ? CMD_STORE : CMD_TICK,
                          12'($urandom_range(0, 4095)), 1'b0, no_reading);
                wait (!hold_request);
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                // Steady input: fill the store around one level, then enough ticks to
                // settle the ring on it, so the whole distance curve gets visited.
                case ($urandom_range(0, 4))
                    0:       target = 619 + $urandom_range(0, 3);
                    1:       target = 128 * $urandom_range(5, 31) + $urandom_range(0, 2) - 1;
                    2:       target = $urandom_range(0, 1) ? 4095 : 0;
                    default: target = $urandom_range(0, 4095);
                endcase
                jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
                repeat (BLOCK_DEPTH)
                begin
                    level = target + $urandom_range(0, 2 * jitter) - jitter;
                    if (level < 0)
                        level = 0;
                    if (level > 4095)
                        level = 4095;
                    offer(CMD_STORE, 12'(level), 1'b0, no_reading);
                end
                repeat ($urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 3))
                    offer(CMD_TICK, 12'($urandom_range(0, 4095)), 1'b0, no_reading);
            end
            else
            begin
                repeat ($urandom_range(1, 24))
                    offer(($urandom_range(0, 2) == 0) ? CMD_TICK : CMD_STORE,
                          12'($urandom_range(0, 4095)), 1'b0, no_reading);
            end
        end

        go_quiet();
        wait (expected_readings.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("ir_range_sensor_filter_chain_unit_tb: clean");
        else
            $display("ir_range_sensor_filter_chain_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/irsf_pkg.sv
src/ir_range_sensor_filter_chain_unit.sv
verif/ir_range_sensor_filter_chain_unit_tb.sv
